FILE: hdl/wsd_pkg.sv
// Shared types, constants and helper functions of the windowed steady-state detector.
// Used by wsd_ctrl, wsd_datapath and windowed_steady_state_detector_top.
// Depends on nothing else.
package wsd_pkg;

    localparam int DEPTH      = 64;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int TIME_W     = 40;
    localparam int DATA_W     = 32;
    localparam int SQ_W       = 64;
    localparam int PROD_W     = 64;
    localparam int Q_W        = 52;
    localparam int HALF_W     = Q_W / 2;
    localparam int SUM_W      = 2 * Q_W + IDX_W;
    localparam int BOUND_W    = SQ_W + IDX_W;
    localparam int LANES      = 5;
    localparam int LANE_W     = $clog2(LANES);
    localparam int DIV_STEPS  = Q_W;
    localparam int SQ_PARTS   = 6;
    localparam int SEQ_W      = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 40;
    localparam int OUT_CNT_W  = 7;

    localparam logic [DATA_W-1:0] US_PER_S     = 32'd1000000;
    localparam logic [TIME_W-1:0] MIN_DT_US    = 40'd1;
    localparam logic [TIME_W-1:0] WINDOW_RESET = 40'd1000000;
    localparam logic [DATA_W-1:0] LIMIT_RESET  = 32'd65536;

    localparam int LANE_AX  = 0;
    localparam int LANE_AY  = 1;
    localparam int LANE_AZ  = 2;
    localparam int LANE_SPD = 3;
    localparam int LANE_YAW = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW = 3'd0,
        CFG_JERK   = 3'd1,
        CFG_ANG    = 3'd2,
        CFG_SPD    = 3'd3,
        CFG_YAW    = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        MO_NONE,
        MO_ANG_X,
        MO_ANG_Y,
        MO_ANG_Z,
        MO_LIM_ANG,
        MO_LIM_SPD,
        MO_LIM_YAW,
        MO_SCALE,
        MO_V_HH,
        MO_V_HL,
        MO_V_LL,
        MO_R_HH,
        MO_R_HL,
        MO_R_LL
    } mul_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_END,
        ST_WRITE,
        ST_PR_RD,
        ST_PR_CHK,
        ST_LIM_A,
        ST_LIM_B,
        ST_LIM_C,
        ST_LIM_END,
        ST_SC_RD,
        ST_SC_CHK,
        ST_SCALE,
        ST_SCALE_END,
        ST_DIV,
        ST_SQV,
        ST_PAIR_END,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] tstamp;
        logic [DATA_W-1:0] ax;
        logic [DATA_W-1:0] ay;
        logic [DATA_W-1:0] az;
        logic [DATA_W-1:0] spd;
        logic [DATA_W-1:0] yaw;
        logic [SQ_W-1:0]   angsq;
    } entry_t;

    typedef struct packed {
        logic              capture;
        mul_op_t           mul_op;
        logic [LANE_W-1:0] lane;
        logic              write;
        logic              rd_oldest;
        logic              drop;
        logic              scan_init;
        logic              rd_scan;
        logic              scan_chk;
        logic              advance;
        logic              load_pair;
        logic              div_step;
        logic              jerk_chk;
        logic              bound_add;
        logic              out_load;
    } cmd_t;

    typedef struct packed {
        logic stale;
        logic count_lt2;
        logic k_zero;
        logic k_last;
        logic pair_ok;
        logic out_free;
    } sts_t;

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] n;
        n = ~x + 32'd1;
        return x[DATA_W-1] ? n : x;
    endfunction

    function automatic logic [DATA_W-1:0] diff_mag(input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b);
        logic [DATA_W:0] d;
        logic [DATA_W:0] n;
        d = {b[DATA_W-1], b} - {a[DATA_W-1], a};
        n = ~d + 33'd1;
        return d[DATA_W] ? n[DATA_W-1:0] : d[DATA_W-1:0];
    endfunction

endpackage

FILE: hdl/wsd_ctrl.sv
// Sequencing state machine of the windowed steady-state detector.
// Depends on wsd_pkg; drives wsd_datapath through cmd_t and reads sts_t.
module wsd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  wsd_pkg::sts_t  sts,
    output wsd_pkg::cmd_t  cmd
);

    wsd_pkg::state_t             state_reg;
    wsd_pkg::state_t             state_next;
    logic [wsd_pkg::SEQ_W-1:0]   cnt_reg;
    logic [wsd_pkg::SEQ_W-1:0]   cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsd_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            wsd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = wsd_pkg::ST_SQ_X;
                end
            end
            wsd_pkg::ST_SQ_X:      state_next = wsd_pkg::ST_SQ_Y;
            wsd_pkg::ST_SQ_Y:      state_next = wsd_pkg::ST_SQ_Z;
            wsd_pkg::ST_SQ_Z:      state_next = wsd_pkg::ST_SQ_END;
            wsd_pkg::ST_SQ_END:    state_next = wsd_pkg::ST_WRITE;
            wsd_pkg::ST_WRITE:     state_next = wsd_pkg::ST_PR_RD;
            wsd_pkg::ST_PR_RD:     state_next = wsd_pkg::ST_PR_CHK;
            wsd_pkg::ST_PR_CHK:
            begin
                state_next = sts.stale ? wsd_pkg::ST_PR_RD : wsd_pkg::ST_LIM_A;
            end
            wsd_pkg::ST_LIM_A:     state_next = wsd_pkg::ST_LIM_B;
            wsd_pkg::ST_LIM_B:     state_next = wsd_pkg::ST_LIM_C;
            wsd_pkg::ST_LIM_C:     state_next = wsd_pkg::ST_LIM_END;
            wsd_pkg::ST_LIM_END:
            begin
                state_next = sts.count_lt2 ? wsd_pkg::ST_FIN : wsd_pkg::ST_SC_RD;
            end
            wsd_pkg::ST_SC_RD:     state_next = wsd_pkg::ST_SC_CHK;
            wsd_pkg::ST_SC_CHK:
            begin
                if (sts.k_zero || !sts.pair_ok)
                begin
                    state_next = sts.k_last ? wsd_pkg::ST_FIN : wsd_pkg::ST_SC_RD;
                end
                else
                begin
                    state_next = wsd_pkg::ST_SCALE;
                    cnt_next   = '0;
                end
            end
            wsd_pkg::ST_SCALE:
            begin
                if (cnt_reg == wsd_pkg::SEQ_W'(wsd_pkg::LANES - 1))
                begin
                    state_next = wsd_pkg::ST_SCALE_END;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            wsd_pkg::ST_SCALE_END: state_next = wsd_pkg::ST_DIV;
            wsd_pkg::ST_DIV:
            begin
                if (cnt_reg == wsd_pkg::SEQ_W'(wsd_pkg::DIV_STEPS - 1))
                begin
                    state_next = wsd_pkg::ST_SQV;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            wsd_pkg::ST_SQV:
            begin
                if (cnt_reg == wsd_pkg::SEQ_W'(wsd_pkg::SQ_PARTS - 1))
                begin
                    state_next = wsd_pkg::ST_PAIR_END;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            wsd_pkg::ST_PAIR_END:
            begin
                state_next = sts.k_last ? wsd_pkg::ST_FIN : wsd_pkg::ST_SC_RD;
            end
            wsd_pkg::ST_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = wsd_pkg::ST_IDLE;
                end
            end
            default:               state_next = wsd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.mul_op = wsd_pkg::MO_NONE;
        in_stall = (state_reg != wsd_pkg::ST_IDLE);
        unique case (state_reg)
            wsd_pkg::ST_IDLE:      cmd.capture = in_valid;
            wsd_pkg::ST_SQ_X:      cmd.mul_op = wsd_pkg::MO_ANG_X;
            wsd_pkg::ST_SQ_Y:      cmd.mul_op = wsd_pkg::MO_ANG_Y;
            wsd_pkg::ST_SQ_Z:      cmd.mul_op = wsd_pkg::MO_ANG_Z;
            wsd_pkg::ST_SQ_END:    cmd.mul_op = wsd_pkg::MO_NONE;
            wsd_pkg::ST_WRITE:     cmd.write = 1'b1;
            wsd_pkg::ST_PR_RD:     cmd.rd_oldest = 1'b1;
            wsd_pkg::ST_PR_CHK:    cmd.drop = sts.stale;
            wsd_pkg::ST_LIM_A:     cmd.mul_op = wsd_pkg::MO_LIM_ANG;
            wsd_pkg::ST_LIM_B:     cmd.mul_op = wsd_pkg::MO_LIM_SPD;
            wsd_pkg::ST_LIM_C:     cmd.mul_op = wsd_pkg::MO_LIM_YAW;
            wsd_pkg::ST_LIM_END:   cmd.scan_init = 1'b1;
            wsd_pkg::ST_SC_RD:     cmd.rd_scan = 1'b1;
            wsd_pkg::ST_SC_CHK:
            begin
                cmd.scan_chk = 1'b1;
                if (sts.k_zero || !sts.pair_ok)
                begin
                    cmd.advance = 1'b1;
                end
                else
                begin
                    cmd.load_pair = 1'b1;
                end
            end
            wsd_pkg::ST_SCALE:
            begin
                cmd.mul_op = wsd_pkg::MO_SCALE;
                cmd.lane   = cnt_reg[wsd_pkg::LANE_W-1:0];
            end
            wsd_pkg::ST_SCALE_END: cmd.mul_op = wsd_pkg::MO_NONE;
            wsd_pkg::ST_DIV:       cmd.div_step = 1'b1;
            wsd_pkg::ST_SQV:
            begin
                cmd.jerk_chk = (cnt_reg == '0);
                unique case (cnt_reg)
                    6'd0:    cmd.mul_op = wsd_pkg::MO_V_HH;
                    6'd1:    cmd.mul_op = wsd_pkg::MO_V_HL;
                    6'd2:    cmd.mul_op = wsd_pkg::MO_V_LL;
                    6'd3:    cmd.mul_op = wsd_pkg::MO_R_HH;
                    6'd4:    cmd.mul_op = wsd_pkg::MO_R_HL;
                    6'd5:    cmd.mul_op = wsd_pkg::MO_R_LL;
                    default: cmd.mul_op = wsd_pkg::MO_NONE;
                endcase
            end
            wsd_pkg::ST_PAIR_END:
            begin
                cmd.advance   = 1'b1;
                cmd.bound_add = 1'b1;
            end
            wsd_pkg::ST_FIN:       cmd.out_load = sts.out_free;
            default:               cmd.mul_op = wsd_pkg::MO_NONE;
        endcase
    end

endmodule

FILE: hdl/wsd_datapath.sv
// Datapath of the windowed steady-state detector: sample memory, shared multiplier,
// five divider lanes, accumulators, configuration and result registers.
// Depends on wsd_pkg; controlled by wsd_ctrl.
module wsd_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wsd_pkg::cmd_t                        cmd,
    output wsd_pkg::sts_t                        sts,
    input  logic                                 cfg_we,
    input  logic [wsd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wsd_pkg::CFG_W-1:0]            cfg_data,
    input  logic [wsd_pkg::TIME_W-1:0]           time_us,
    input  logic signed [wsd_pkg::DATA_W-1:0]    accel_x,
    input  logic signed [wsd_pkg::DATA_W-1:0]    accel_y,
    input  logic signed [wsd_pkg::DATA_W-1:0]    accel_z,
    input  logic signed [wsd_pkg::DATA_W-1:0]    speed,
    input  logic signed [wsd_pkg::DATA_W-1:0]    yaw_rate,
    input  logic signed [wsd_pkg::DATA_W-1:0]    ang_accel_x,
    input  logic signed [wsd_pkg::DATA_W-1:0]    ang_accel_y,
    input  logic signed [wsd_pkg::DATA_W-1:0]    ang_accel_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 steady,
    output logic [wsd_pkg::OUT_CNT_W-1:0]        window_count
);

    wsd_pkg::entry_t mem [wsd_pkg::DEPTH];
    wsd_pkg::entry_t rd_reg;
    wsd_pkg::entry_t prev_reg;
    wsd_pkg::entry_t wr_entry;

    logic [wsd_pkg::TIME_W-1:0]   win_reg;
    logic [wsd_pkg::DATA_W-1:0]   jerk_reg;
    logic [wsd_pkg::DATA_W-1:0]   ang_lim_reg;
    logic [wsd_pkg::DATA_W-1:0]   spd_lim_reg;
    logic [wsd_pkg::DATA_W-1:0]   yaw_lim_reg;

    logic [wsd_pkg::IDX_W-1:0]    oldest_reg;
    logic [wsd_pkg::CNT_W-1:0]    count_reg;
    logic [wsd_pkg::CNT_W-1:0]    k_reg;
    logic                         ok_reg;
    logic                         any_pair_reg;
    logic                         out_valid_reg;
    logic                         steady_reg;
    logic [wsd_pkg::OUT_CNT_W-1:0] window_count_reg;

    logic [wsd_pkg::TIME_W-1:0]   t_reg;
    logic [wsd_pkg::DATA_W-1:0]   ax_reg;
    logic [wsd_pkg::DATA_W-1:0]   ay_reg;
    logic [wsd_pkg::DATA_W-1:0]   az_reg;
    logic [wsd_pkg::DATA_W-1:0]   spd_reg;
    logic [wsd_pkg::DATA_W-1:0]   yaw_reg;
    logic [wsd_pkg::DATA_W-1:0]   mx_reg;
    logic [wsd_pkg::DATA_W-1:0]   my_reg;
    logic [wsd_pkg::DATA_W-1:0]   mz_reg;
    logic [wsd_pkg::SQ_W-1:0]     angsq_reg;

    logic [wsd_pkg::SQ_W-1:0]     anglim2_reg;
    logic [wsd_pkg::SQ_W-1:0]     spdlim2_reg;
    logic [wsd_pkg::SQ_W-1:0]     yawlim2_reg;

    logic [wsd_pkg::DATA_W-1:0]   d_reg [wsd_pkg::LANES];
    logic [wsd_pkg::TIME_W-1:0]   dt_reg;
    logic [wsd_pkg::Q_W-1:0]      num_reg [wsd_pkg::LANES];
    logic [wsd_pkg::TIME_W-1:0]   rem_reg [wsd_pkg::LANES];
    logic [wsd_pkg::TIME_W:0]     shifted [wsd_pkg::LANES];
    logic [wsd_pkg::TIME_W:0]     trial [wsd_pkg::LANES];

    logic [wsd_pkg::SUM_W-1:0]    sum_v_reg;
    logic [wsd_pkg::SUM_W-1:0]    sum_r_reg;
    logic [wsd_pkg::BOUND_W-1:0]  bound_v_reg;
    logic [wsd_pkg::BOUND_W-1:0]  bound_r_reg;

    logic [wsd_pkg::DATA_W-1:0]   mul_a;
    logic [wsd_pkg::DATA_W-1:0]   mul_b;
    logic [wsd_pkg::PROD_W-1:0]   prod_reg;
    wsd_pkg::mul_op_t             tag_reg;
    logic [wsd_pkg::LANE_W-1:0]   tag_lane_reg;

    logic [wsd_pkg::HALF_W-1:0]   v_hi;
    logic [wsd_pkg::HALF_W-1:0]   v_lo;
    logic [wsd_pkg::HALF_W-1:0]   r_hi;
    logic [wsd_pkg::HALF_W-1:0]   r_lo;

    logic [wsd_pkg::IDX_W-1:0]    wr_idx;
    logic [wsd_pkg::IDX_W-1:0]    rd_idx;
    logic [wsd_pkg::TIME_W-1:0]   pair_dt;
    logic [wsd_pkg::TIME_W-1:0]   age;
    logic [wsd_pkg::CNT_W-1:0]    k_inc;
    logic                         jerk_bad;
    logic                         steady_calc;

    assign wr_idx = oldest_reg + count_reg[wsd_pkg::IDX_W-1:0];
    assign rd_idx = cmd.rd_scan ? oldest_reg + k_reg[wsd_pkg::IDX_W-1:0] : oldest_reg;
    assign pair_dt = rd_reg.tstamp - prev_reg.tstamp;
    assign age     = t_reg - rd_reg.tstamp;
    assign k_inc   = k_reg + 1'b1;

    assign v_hi = num_reg[wsd_pkg::LANE_SPD][wsd_pkg::Q_W-1:wsd_pkg::HALF_W];
    assign v_lo = num_reg[wsd_pkg::LANE_SPD][wsd_pkg::HALF_W-1:0];
    assign r_hi = num_reg[wsd_pkg::LANE_YAW][wsd_pkg::Q_W-1:wsd_pkg::HALF_W];
    assign r_lo = num_reg[wsd_pkg::LANE_YAW][wsd_pkg::HALF_W-1:0];

    always_comb
    begin
        wr_entry.tstamp = t_reg;
        wr_entry.ax     = ax_reg;
        wr_entry.ay     = ay_reg;
        wr_entry.az     = az_reg;
        wr_entry.spd    = spd_reg;
        wr_entry.yaw    = yaw_reg;
        wr_entry.angsq  = angsq_reg;
    end

    always_comb
    begin
        sts.stale     = (t_reg >= rd_reg.tstamp) && (age > win_reg) && (count_reg != '0);
        sts.count_lt2 = (count_reg < wsd_pkg::CNT_W'(2));
        sts.k_zero    = (k_reg == '0);
        sts.k_last    = (k_inc == count_reg);
        sts.pair_ok   = (rd_reg.tstamp >= prev_reg.tstamp) && (pair_dt > wsd_pkg::MIN_DT_US);
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        unique case (cmd.mul_op)
            wsd_pkg::MO_ANG_X:   begin mul_a = mx_reg;      mul_b = mx_reg;      end
            wsd_pkg::MO_ANG_Y:   begin mul_a = my_reg;      mul_b = my_reg;      end
            wsd_pkg::MO_ANG_Z:   begin mul_a = mz_reg;      mul_b = mz_reg;      end
            wsd_pkg::MO_LIM_ANG: begin mul_a = ang_lim_reg; mul_b = ang_lim_reg; end
            wsd_pkg::MO_LIM_SPD: begin mul_a = spd_lim_reg; mul_b = spd_lim_reg; end
            wsd_pkg::MO_LIM_YAW: begin mul_a = yaw_lim_reg; mul_b = yaw_lim_reg; end
            wsd_pkg::MO_SCALE:
            begin
                mul_a = d_reg[cmd.lane];
                mul_b = wsd_pkg::US_PER_S;
            end
            wsd_pkg::MO_V_HH:
            begin
                mul_a = wsd_pkg::DATA_W'(v_hi);
                mul_b = wsd_pkg::DATA_W'(v_hi);
            end
            wsd_pkg::MO_V_HL:
            begin
                mul_a = wsd_pkg::DATA_W'(v_hi);
                mul_b = wsd_pkg::DATA_W'(v_lo);
            end
            wsd_pkg::MO_V_LL:
            begin
                mul_a = wsd_pkg::DATA_W'(v_lo);
                mul_b = wsd_pkg::DATA_W'(v_lo);
            end
            wsd_pkg::MO_R_HH:
            begin
                mul_a = wsd_pkg::DATA_W'(r_hi);
                mul_b = wsd_pkg::DATA_W'(r_hi);
            end
            wsd_pkg::MO_R_HL:
            begin
                mul_a = wsd_pkg::DATA_W'(r_hi);
                mul_b = wsd_pkg::DATA_W'(r_lo);
            end
            wsd_pkg::MO_R_LL:
            begin
                mul_a = wsd_pkg::DATA_W'(r_lo);
                mul_b = wsd_pkg::DATA_W'(r_lo);
            end
            default:             begin mul_a = '0;          mul_b = '0;          end
        endcase
    end

    always_comb
    begin
        for (int l = 0; l < wsd_pkg::LANES; l++)
        begin
            shifted[l] = {rem_reg[l], num_reg[l][wsd_pkg::Q_W-1]};
            trial[l]   = shifted[l] - {1'b0, dt_reg};
        end
    end

    assign jerk_bad = (num_reg[wsd_pkg::LANE_AX] > wsd_pkg::Q_W'(jerk_reg)) ||
                      (num_reg[wsd_pkg::LANE_AY] > wsd_pkg::Q_W'(jerk_reg)) ||
                      (num_reg[wsd_pkg::LANE_AZ] > wsd_pkg::Q_W'(jerk_reg));

    assign steady_calc = ok_reg && any_pair_reg &&
                         (sum_v_reg <= wsd_pkg::SUM_W'(bound_v_reg)) &&
                         (sum_r_reg <= wsd_pkg::SUM_W'(bound_r_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[wr_idx] <= wr_entry;
        end
        if (cmd.rd_oldest || cmd.rd_scan)
        begin
            rd_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg          <= wsd_pkg::WINDOW_RESET;
            jerk_reg         <= wsd_pkg::LIMIT_RESET;
            ang_lim_reg      <= wsd_pkg::LIMIT_RESET;
            spd_lim_reg      <= wsd_pkg::LIMIT_RESET;
            yaw_lim_reg      <= wsd_pkg::LIMIT_RESET;
            oldest_reg       <= '0;
            count_reg        <= '0;
            k_reg            <= '0;
            ok_reg           <= 1'b0;
            any_pair_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            tag_reg          <= wsd_pkg::MO_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    wsd_pkg::CFG_WINDOW: win_reg     <= cfg_data;
                    wsd_pkg::CFG_JERK:   jerk_reg    <= cfg_data[wsd_pkg::DATA_W-1:0];
                    wsd_pkg::CFG_ANG:    ang_lim_reg <= cfg_data[wsd_pkg::DATA_W-1:0];
                    wsd_pkg::CFG_SPD:    spd_lim_reg <= cfg_data[wsd_pkg::DATA_W-1:0];
                    wsd_pkg::CFG_YAW:    yaw_lim_reg <= cfg_data[wsd_pkg::DATA_W-1:0];
                    default:             win_reg     <= win_reg;
                endcase
            end

            tag_reg <= cmd.mul_op;

            if (cmd.capture && count_reg == wsd_pkg::CNT_W'(wsd_pkg::DEPTH))
            begin
                oldest_reg <= oldest_reg + 1'b1;
                count_reg  <= wsd_pkg::CNT_W'(wsd_pkg::DEPTH - 1);
            end
            else if (cmd.write)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.drop)
            begin
                oldest_reg <= oldest_reg + 1'b1;
                count_reg  <= count_reg - 1'b1;
            end

            if (cmd.scan_init)
            begin
                k_reg        <= '0;
                ok_reg       <= 1'b1;
                any_pair_reg <= 1'b0;
            end
            else
            begin
                if (cmd.advance)
                begin
                    k_reg <= k_inc;
                end
                if ((cmd.scan_chk && rd_reg.angsq > anglim2_reg) ||
                    (cmd.jerk_chk && jerk_bad))
                begin
                    ok_reg <= 1'b0;
                end
                if (cmd.bound_add)
                begin
                    any_pair_reg <= 1'b1;
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= mul_a * mul_b;
        tag_lane_reg <= cmd.lane;

        if (cmd.capture)
        begin
            t_reg   <= time_us;
            ax_reg  <= accel_x;
            ay_reg  <= accel_y;
            az_reg  <= accel_z;
            spd_reg <= speed;
            yaw_reg <= yaw_rate;
            mx_reg  <= wsd_pkg::mag32(ang_accel_x);
            my_reg  <= wsd_pkg::mag32(ang_accel_y);
            mz_reg  <= wsd_pkg::mag32(ang_accel_z);
        end

        if (cmd.scan_init)
        begin
            sum_v_reg   <= '0;
            sum_r_reg   <= '0;
            bound_v_reg <= '0;
            bound_r_reg <= '0;
        end
        else
        begin
            unique case (tag_reg)
                wsd_pkg::MO_V_HH: sum_v_reg <= sum_v_reg +
                                   (wsd_pkg::SUM_W'(prod_reg) << (2 * wsd_pkg::HALF_W));
                wsd_pkg::MO_V_HL: sum_v_reg <= sum_v_reg +
                                   (wsd_pkg::SUM_W'(prod_reg) << (wsd_pkg::HALF_W + 1));
                wsd_pkg::MO_V_LL: sum_v_reg <= sum_v_reg + wsd_pkg::SUM_W'(prod_reg);
                wsd_pkg::MO_R_HH: sum_r_reg <= sum_r_reg +
                                   (wsd_pkg::SUM_W'(prod_reg) << (2 * wsd_pkg::HALF_W));
                wsd_pkg::MO_R_HL: sum_r_reg <= sum_r_reg +
                                   (wsd_pkg::SUM_W'(prod_reg) << (wsd_pkg::HALF_W + 1));
                wsd_pkg::MO_R_LL: sum_r_reg <= sum_r_reg + wsd_pkg::SUM_W'(prod_reg);
                default:          sum_v_reg <= sum_v_reg;
            endcase
            if (cmd.bound_add)
            begin
                bound_v_reg <= bound_v_reg + wsd_pkg::BOUND_W'(spdlim2_reg);
                bound_r_reg <= bound_r_reg + wsd_pkg::BOUND_W'(yawlim2_reg);
            end
        end

        unique case (tag_reg)
            wsd_pkg::MO_ANG_X:   angsq_reg   <= prod_reg;
            wsd_pkg::MO_ANG_Y:   angsq_reg   <= angsq_reg + prod_reg;
            wsd_pkg::MO_ANG_Z:   angsq_reg   <= angsq_reg + prod_reg;
            wsd_pkg::MO_LIM_ANG: anglim2_reg <= prod_reg;
            wsd_pkg::MO_LIM_SPD: spdlim2_reg <= prod_reg;
            wsd_pkg::MO_LIM_YAW: yawlim2_reg <= prod_reg;
            wsd_pkg::MO_SCALE:
            begin
                num_reg[tag_lane_reg] <= prod_reg[wsd_pkg::Q_W-1:0];
                rem_reg[tag_lane_reg] <= '0;
            end
            default:             angsq_reg   <= angsq_reg;
        endcase

        if (cmd.load_pair)
        begin
            d_reg[wsd_pkg::LANE_AX]  <= wsd_pkg::diff_mag(prev_reg.ax, rd_reg.ax);
            d_reg[wsd_pkg::LANE_AY]  <= wsd_pkg::diff_mag(prev_reg.ay, rd_reg.ay);
            d_reg[wsd_pkg::LANE_AZ]  <= wsd_pkg::diff_mag(prev_reg.az, rd_reg.az);
            d_reg[wsd_pkg::LANE_SPD] <= wsd_pkg::diff_mag(prev_reg.spd, rd_reg.spd);
            d_reg[wsd_pkg::LANE_YAW] <= wsd_pkg::diff_mag(prev_reg.yaw, rd_reg.yaw);
            dt_reg                   <= pair_dt;
        end

        if (cmd.div_step)
        begin
            for (int l = 0; l < wsd_pkg::LANES; l++)
            begin
                if (!trial[l][wsd_pkg::TIME_W])
                begin
                    rem_reg[l] <= trial[l][wsd_pkg::TIME_W-1:0];
                    num_reg[l] <= {num_reg[l][wsd_pkg::Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[l] <= shifted[l][wsd_pkg::TIME_W-1:0];
                    num_reg[l] <= {num_reg[l][wsd_pkg::Q_W-2:0], 1'b0};
                end
            end
        end

        if (cmd.advance)
        begin
            prev_reg <= rd_reg;
        end

        if (cmd.out_load)
        begin
            steady_reg       <= steady_calc;
            window_count_reg <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign steady       = steady_reg;
    assign window_count = window_count_reg;

`ifndef SYNTH
    a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> count_reg < wsd_pkg::CNT_W'(wsd_pkg::DEPTH))
        else $error("sample stored into a full window");
    a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (count_reg != '0) && (count_reg <= wsd_pkg::CNT_W'(wsd_pkg::DEPTH)))
        else $error("result window count out of range");
    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> rem_reg[0] < dt_reg)
        else $error("divider remainder not below divisor");
    a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_scan |-> k_reg < count_reg)
        else $error("scan read beyond kept samples");
`endif

endmodule

FILE: hdl/windowed_steady_state_detector_top.sv
// Top level of the windowed steady-state detector.
// Depends on wsd_pkg, wsd_ctrl and wsd_datapath.
//
// One sample is taken per request and gives exactly one result. After a sample is taken,
// the block stalls its input until the result is in the output register; the output
// register lets the next sample enter while the result waits. Samples older than the
// window are dropped as stale, at most 64 samples are kept, and only sample pairs with a
// time step above one microsecond are used. Each such pair goes through the 52-step
// restoring divider that forms all five derivatives in parallel, plus the shared 32x32
// multiplier used for the scaling and for the squares.
// Configuration must be written only while the block is idle; the block itself does not
// enforce this.
module windowed_steady_state_detector_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [wsd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wsd_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [wsd_pkg::TIME_W-1:0]           time_us,
    input  logic signed [wsd_pkg::DATA_W-1:0]    accel_x,
    input  logic signed [wsd_pkg::DATA_W-1:0]    accel_y,
    input  logic signed [wsd_pkg::DATA_W-1:0]    accel_z,
    input  logic signed [wsd_pkg::DATA_W-1:0]    speed,
    input  logic signed [wsd_pkg::DATA_W-1:0]    yaw_rate,
    input  logic signed [wsd_pkg::DATA_W-1:0]    ang_accel_x,
    input  logic signed [wsd_pkg::DATA_W-1:0]    ang_accel_y,
    input  logic signed [wsd_pkg::DATA_W-1:0]    ang_accel_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 steady,
    output logic [wsd_pkg::OUT_CNT_W-1:0]        window_count
);

    wsd_pkg::cmd_t cmd;
    wsd_pkg::sts_t sts;

    wsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    wsd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .time_us      (time_us),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .speed        (speed),
        .yaw_rate     (yaw_rate),
        .ang_accel_x  (ang_accel_x),
        .ang_accel_y  (ang_accel_y),
        .ang_accel_z  (ang_accel_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .steady       (steady),
        .window_count (window_count)
    );

endmodule
